>>> rtl/core/matrix3x3_inverse_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse unit
// Each macro expands to a labelled concurrent assertion, or to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3X3_INVERSE_UNIT_MACROS_SVH
`ifndef SYNTH
`define M3I_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define M3I_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define M3I_ASSERT_IMPL(label, clk, rst_n, prop)
`define M3I_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants of the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package m3inv_pkg;
  localparam int DEF_FRAC_BITS = 16;
  localparam int ELEM_W = 32;
  localparam int DET_W  = 98;
  localparam int COF_W  = 65;
  localparam int Q_W    = 33;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t mat_t [9];
endpackage

>>> rtl/core/matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Accepts one matrix per cycle while full is low and delivers its inverse, in
// order, on the output ports: four front stages form cofactors and
// determinant, 34 stages of pipelined restoring division (an input stage, then
// one quotient bit per stage, in each of nine lanes) follow, and a four-entry
// output queue is written last. Full is high only while that queue holds
// four results, and then the whole pipeline holds; with pop kept high a new
// beat is taken on every cycle. A singular matrix yields the identity with
// out_singular set.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit #(
  parameter int FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic signed [31:0]   in_a11, in_a12, in_a13,
  input  logic signed [31:0]   in_a21, in_a22, in_a23,
  input  logic signed [31:0]   in_a31, in_a32, in_a33,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   out_r11, out_r12, out_r13,
  output logic signed [31:0]   out_r21, out_r22, out_r23,
  output logic signed [31:0]   out_r31, out_r32, out_r33,
  output logic                 out_singular
);
  import m3inv_pkg::*;
`include "matrix3x3_inverse_unit_macros.svh"

  mat_t in_mat, res;
  logic stall, f_vld, f_sing;
  logic signed [COF_W-1:0] f_cof [9];
  logic signed [DET_W-1:0] f_det;
  logic [2:0] qcnt;

  assign in_mat = '{in_a11, in_a12, in_a13, in_a21, in_a22, in_a23,
                    in_a31, in_a32, in_a33};
  assign full = stall;

  m3inv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(push && !full), .in_mat(in_mat),
    .stall(stall), .out_vld(f_vld), .out_cof(f_cof), .out_det(f_det),
    .out_sing(f_sing));

  m3inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(f_vld), .in_cof(f_cof), .in_det(f_det),
    .in_sing(f_sing), .pop(pop), .stall(stall), .empty(empty), .res(res),
    .sing(out_singular), .lat_cnt(qcnt));

  assign out_r11 = res[0];
  assign out_r12 = res[1];
  assign out_r13 = res[2];
  assign out_r21 = res[3];
  assign out_r22 = res[4];
  assign out_r23 = res[5];
  assign out_r31 = res[6];
  assign out_r32 = res[7];
  assign out_r33 = res[8];

  `M3I_ASSERT_NEVER(a_cnt_range, clk, rst_n, qcnt > 3'd4)
  `M3I_ASSERT_IMPL(a_empty_cnt, clk, rst_n, empty == (qcnt == 3'd0))
  `M3I_ASSERT_IMPL(a_pop_drains, clk, rst_n, (pop && !empty && qcnt == 3'd1 && !stall) |=> (qcnt <= 3'd1))
endmodule

>>> rtl/core/m3inv_front.sv
// ----------------------------------------------------------------------------
// m3inv_front
// Front end: forms the cofactors and the determinant in a four-stage pipeline
// and flags singular matrices.
// ----------------------------------------------------------------------------
module m3inv_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  m3inv_pkg::mat_t          in_mat,
  input  logic                     stall,
  output logic                     out_vld,
  output logic signed [m3inv_pkg::COF_W-1:0] out_cof [9],
  output logic signed [m3inv_pkg::DET_W-1:0] out_det,
  output logic                     out_sing
);
  import m3inv_pkg::*;

  logic signed [63:0] p1_r [18];
  logic signed [63:0] p1_nxt [18];
  elem_t             e1_r [9];
  logic              v1_r, v2_r, v3_r, v4_r;
  logic signed [COF_W-1:0] cof2_r [9];
  logic signed [COF_W-1:0] cof2_nxt [9];
  elem_t             e2_r [9];
  logic signed [64:0] ph_r [3];
  logic signed [64:0] ph_nxt [3];
  logic signed [64:0] pl_r [3];
  logic signed [64:0] pl_nxt [3];
  logic signed [COF_W-1:0] cof3_r [9];
  logic signed [COF_W-1:0] cof4_r [9];
  logic signed [DET_W-1:0] det_r;
  logic signed [DET_W-1:0] det_nxt;

  localparam int CI [9][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p1_nxt[2*i]   = 64'(in_mat[CI[i][0]]) * 64'(in_mat[CI[i][1]]);
      p1_nxt[2*i+1] = 64'(in_mat[CI[i][2]]) * 64'(in_mat[CI[i][3]]);
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cof2_nxt[i] = COF_W'(p1_r[2*i]) - COF_W'(p1_r[2*i+1]);
    end
  end

  // Expansion along the first row: det = a11*C11 + a12*C12 + a13*C13. Each
  // cofactor is split at bit 32, so every product is at most 33 by 32 bits.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph_nxt[k] = 65'($signed(cof2_r[3*k][COF_W-1:32])) * 65'(e2_r[k]);
      pl_nxt[k] = 65'($signed({1'b0, cof2_r[3*k][31:0]})) * 65'(e2_r[k]);
    end
  end

  assign det_nxt = ((DET_W'(ph_r[0]) + DET_W'(ph_r[1]) + DET_W'(ph_r[2])) <<< 32)
                 + DET_W'(pl_r[0]) + DET_W'(pl_r[1]) + DET_W'(pl_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      p1_r   <= p1_nxt;
      e1_r   <= in_mat;
      cof2_r <= cof2_nxt;
      e2_r   <= e1_r;
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      cof3_r <= cof2_r;
      det_r  <= det_nxt;
      cof4_r <= cof3_r;
    end
  end

  assign out_vld  = v4_r;
  assign out_cof  = cof4_r;
  assign out_det  = det_r;
  assign out_sing = (det_r == '0);
endmodule

>>> rtl/core/m3inv_divlane.sv
// ----------------------------------------------------------------------------
// m3inv_divlane
// One pipelined restoring divider lane: |cof| * 2^(2F) / |det|, with sign
// and saturation applied at the end. One quotient bit per stage.
// ----------------------------------------------------------------------------
module m3inv_divlane #(
  parameter int FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [m3inv_pkg::COF_W-1:0] cof,
  input  logic [m3inv_pkg::DET_W-1:0]       dmag,
  input  logic                              neg_in,
  output logic signed [m3inv_pkg::ELEM_W-1:0] res
);
  import m3inv_pkg::*;

  localparam int NS = Q_W;
  localparam int SH = 2 * FRAC_BITS;
  localparam int NUM_W = COF_W + SH;
  localparam int R_W = DET_W + 1;

  logic [NUM_W-1:0] num;
  logic [R_W-1:0]   rem_r  [NS+1];
  logic [NUM_W-1:0] nsh_r  [NS+1];
  logic [DET_W-1:0] d_r    [NS+1];
  logic [NS-1:0]    q_r    [NS+1];
  logic             ovf_r  [NS+1];
  logic             neg_r  [NS+1];
  logic [COF_W-1:0] cmag;
  logic [R_W-1:0]   pre_rem;
  logic             pre_ovf;

  assign cmag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
  assign num  = NUM_W'(cmag) << SH;

  // Quotient bits at or above NS only show overflow: top part >= divisor.
  always_comb begin
    pre_ovf = ((NUM_W - NS) > 0) &&
              ({{(DET_W + NS){1'b0}}, num} >> NS) >= {{(NUM_W + NS){1'b0}}, dmag};
    pre_rem = R_W'(num >> NS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= pre_rem;
      nsh_r[0] <= num;
      d_r[0]   <= dmag;
      q_r[0]   <= '0;
      ovf_r[0] <= pre_ovf;
      neg_r[0] <= neg_in;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [R_W:0] trial;
    logic [R_W:0] rshift;
    assign rshift = {rem_r[s], nsh_r[s][NS-1-s]};
    assign trial  = rshift - {2'b00, d_r[s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= trial[R_W] ? R_W'(rshift) : R_W'(trial);
        q_r[s+1]   <= {q_r[s][NS-2:0], ~trial[R_W]};
        nsh_r[s+1] <= nsh_r[s];
        d_r[s+1]   <= d_r[s];
        ovf_r[s+1] <= ovf_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  always_comb begin
    if (!neg_r[NS]) begin
      if (ovf_r[NS] || (q_r[NS] > 33'h0_7FFF_FFFF)) begin
        res = 32'sh7FFF_FFFF;
      end else begin
        res = ELEM_W'(q_r[NS]);
      end
    end else begin
      if (ovf_r[NS] || (q_r[NS] > 33'h0_8000_0000)) begin
        res = 32'sh8000_0000;
      end else begin
        res = ELEM_W'(-q_r[NS]);
      end
    end
  end
endmodule

>>> rtl/core/m3inv_back.sv
// ----------------------------------------------------------------------------
// m3inv_back
// Back end: nine divider lanes in lock step, result selection for
// singular matrices and the output queue.
// ----------------------------------------------------------------------------
module m3inv_back #(
  parameter int FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [m3inv_pkg::COF_W-1:0] in_cof [9],
  input  logic signed [m3inv_pkg::DET_W-1:0] in_det,
  input  logic                              in_sing,
  input  logic                              pop,
  output logic                              stall,
  output logic                              empty,
  output m3inv_pkg::mat_t                   res,
  output logic                              sing,
  output logic [2:0]                        lat_cnt
);
  import m3inv_pkg::*;

  localparam int LAT = Q_W + 1;
  localparam int QD = 4;

  logic [DET_W-1:0] dmag;
  logic             dneg;
  logic             adv;
  logic [LAT-1:0]   v_r;
  logic [LAT-1:0]   s_r;
  elem_t            lane [9];
  elem_t            pick [9];
  elem_t            qm  [QD][9];
  logic             qs  [QD];
  logic [1:0]       wp_r, rp_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             push_q, pop_q;

  assign dneg = in_det[DET_W-1];
  assign dmag = dneg ? DET_W'(-in_det) : DET_W'(in_det);

  // The pipeline advances while the output queue has room.
  assign adv   = cnt_r < 3'(QD);
  assign stall = !adv;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3inv_divlane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .adv(adv), .cof(in_cof[i]),
      .dmag(in_sing ? {{(DET_W-1){1'b0}}, 1'b1} : dmag),
      .neg_in(in_cof[i][COF_W-1] != dneg), .res(lane[i]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s_r <= {s_r[LAT-2:0], in_sing};
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (s_r[LAT-1]) begin
        pick[i] = (i % 4 == 0) ? elem_t'(33'd1 << FRAC_BITS) : '0;
      end else begin
        pick[i] = lane[i];
      end
    end
  end

  assign push_q = adv && v_r[LAT-1];
  assign pop_q  = pop && (cnt_r != '0);
  assign cnt_nxt = cnt_r + {2'b00, push_q} - {2'b00, pop_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_q) wp_r <= wp_r + 2'd1;
      if (pop_q)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      qm[wp_r] <= pick;
      qs[wp_r] <= s_r[LAT-1];
    end
  end

  assign res     = qm[rp_r];
  assign sing    = qs[rp_r];
  assign empty   = (cnt_r == '0);
  assign lat_cnt = cnt_r;
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the 3x3 matrix inverse unit
// Drives matrices into the unit through its push/full side and drains
// inverses through its empty/pop side, both with random gaps. Each result is
// checked field by field against an exact fixed-point adjugate inverse that
// is worked out here when the matrix is accepted.
// ----------------------------------------------------------------------------
module tb;
  import m3inv_pkg::*;

  typedef struct {
    elem_t r[9];
    bit    singular;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t awaited[$];
    int       errors;
    int       checked;
    int       singular_seen;
    int       saturated_seen;

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function inverse_t invert(elem_t a[9]);
      localparam int F = DEF_FRAC_BITS;
      int cof_ops[9][4] = '{'{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
                            '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
                            '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};
      logic signed [127:0] e[9];
      logic signed [127:0] det, cof;
      logic [127:0]        dmag, num, quo;
      bit                  neg;
      inverse_t            res;
      for (int i = 0; i < 9; i++) e[i] = a[i];
      det = e[0]*e[4]*e[8] + e[3]*e[7]*e[2] + e[6]*e[1]*e[5]
          - e[6]*e[4]*e[2] - e[3]*e[1]*e[8] - e[0]*e[7]*e[5];
      if (det == 0) begin
        for (int i = 0; i < 9; i++) res.r[i] = (i % 4 == 0) ? elem_t'(1 << F) : '0;
        res.singular = 1'b1;
        return res;
      end
      dmag = (det < 0) ? -det : det;
      for (int i = 0; i < 9; i++) begin
        cof = e[cof_ops[i][0]]*e[cof_ops[i][1]] - e[cof_ops[i][2]]*e[cof_ops[i][3]];
        neg = (cof < 0) != (det < 0);
        num = ((cof < 0) ? -cof : cof);
        num = num << (2 * F);
        quo = num / dmag;
        if (!neg) res.r[i] = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        else res.r[i] = (quo > 128'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
        if (!neg && quo > 128'h7FFF_FFFF || neg && quo > 128'h8000_0000) saturated_seen++;
      end
      res.singular = 1'b0;
      return res;
    endfunction

    function void note_matrix(elem_t a[9]);
      awaited.push_back(invert(a));
    endfunction

    task check_inverse(inverse_t got);
      inverse_t want;
      if (awaited.size() == 0) begin
        report("inverse delivered with none awaited");
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.singular) singular_seen++;
      for (int i = 0; i < 9; i++)
        if (got.r[i] !== want.r[i])
          report($sformatf("r%0d%0d got %h want %h", i / 3 + 1, i % 3 + 1, got.r[i],
                           want.r[i]));
      if (got.singular !== want.singular)
        report($sformatf("singular got %b want %b", got.singular, want.singular));
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  push = 1'b0;
  logic  pop = 1'b0;
  logic  full, empty;
  elem_t mat [9];
  elem_t res_r [9];
  logic  out_singular;
  bit    hold_off = 1'b0;
  bit    accepted_beat;
  int    idle_cycles = 0;
  int    sent = 0;
  inverse_scoreboard board = new();

  initial for (int i = 0; i < 9; i++) mat[i] = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  matrix3x3_inverse_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_a11(mat[0]), .in_a12(mat[1]), .in_a13(mat[2]),
    .in_a21(mat[3]), .in_a22(mat[4]), .in_a23(mat[5]),
    .in_a31(mat[6]), .in_a32(mat[7]), .in_a33(mat[8]),
    .empty(empty), .pop(pop),
    .out_r11(res_r[0]), .out_r12(res_r[1]), .out_r13(res_r[2]),
    .out_r21(res_r[3]), .out_r22(res_r[4]), .out_r23(res_r[5]),
    .out_r31(res_r[6]), .out_r32(res_r[7]), .out_r33(res_r[8]),
    .out_singular(out_singular)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_matrix(elem_t m[9]);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) mat[i] <= m[i];
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_matrix(m);
    sent++;
  endtask

  function automatic elem_t small_elem();
    return elem_t'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
  endfunction

  task automatic send_random();
    elem_t m[9];
    int    kind, s;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 45) m[i] = small_elem();
      else if (kind < 65) m[i] = $urandom();
      else if (kind < 80) m[i] = elem_t'($signed($urandom_range(2047)) - 1024);
      else m[i] = small_elem() >>> $urandom_range(12);
    end
    if (kind >= 85) begin
      s = $urandom_range(2);
      case ($urandom_range(2))
        0: for (int c = 0; c < 3; c++) m[3 * ((s + 1) % 3) + c] = m[3 * s + c];
        1: for (int r = 0; r < 3; r++) m[3 * r + s] = '0;
        default: for (int c = 0; c < 3; c++) m[3 * ((s + 2) % 3) + c] = -m[3 * s + c];
      endcase
    end
    send_matrix(m);
  endtask

  task automatic send_directed();
    elem_t m[9];
    elem_t one;
    one = elem_t'(1 << DEF_FRAC_BITS);
    m = '{default: '0};
    send_matrix(m);
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};
    send_matrix(m);
    m = '{-one, 0, 0, 0, one, 0, 0, 0, one};
    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
    send_matrix(m);
    m = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
    send_matrix(m);
    m = '{default: 32'h8000_0000};
    send_matrix(m);
    m = '{default: 32'h7FFF_FFFF};
    send_matrix(m);
    m = '{default: 32'hFFFF_FFFF};
    send_matrix(m);
    m = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1};
    send_matrix(m);
    m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    send_matrix(m);
    m = '{0, one, 0, one, 0, 0, 0, 0, one};
    send_matrix(m);
    m = '{2 * one, one, 0, one, 2 * one, one, 0, one, 2 * one};
    send_matrix(m);
    m = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
    send_matrix(m);
    m = '{1, 0, 0, 0, -1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3C3C_3C3C};
    send_matrix(m);
  endtask

  // Result side: random pops, with one long hold-off on request.
  initial begin
    inverse_t got;
    int       gap;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      for (int i = 0; i < 9; i++) got.r[i] = res_r[i];
      got.singular = out_singular;
      board.check_inverse(got);
    end
  end

  always @(posedge clk) begin
    accepted_beat = (push && !full) || (pop && !empty);
    if (!rst_n || accepted_beat) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    hold_off = 1'b1;
    for (int n = 0; n < 1800; n++) begin
      if (n == 900) begin
        push <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
      end
      send_random();
    end
    push <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Inverted %0d matrices, %0d checked, %0d singular, %0d saturated elements.",
             sent, board.checked, board.singular_seen, board.saturated_seen);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/m3inv_pkg.sv
rtl/core/m3inv_front.sv
rtl/core/m3inv_divlane.sv
rtl/core/m3inv_back.sv
rtl/core/matrix3x3_inverse_unit.sv
bench/tb.sv
